FILE: rtl/ple_pkg.sv
`default_nettype none

package ple_pkg;

   localparam int KIND_W   = 3;
   localparam int POS_W    = 11;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   localparam logic [KIND_W-1:0] KIND_READ       = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INS_HEAD   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_INS_TAIL   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_INS_AT     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DELETE     = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   localparam logic signed [VALUE_W-1:0] READ_MISS = -32'sd1;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] read_value;
      logic [STATUS_W-1:0]       status;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/positional_list_engine.sv
// Positional list engine: an ordered list of signed 32-bit values kept as a
// doubly linked chain in on-chip node memories, with a stack of freed slots.
// Requests arrive on the req_ channel (valid/stall), one response per request
// leaves on the rsp_ channel (valid/stall) from an output register.
// One request is worked on at a time; req_stall is high while it is in flight.
// A rejected request goes straight to the response stage; inserts first take a
// slot, walk only for a middle position, write the new node, then link it in
// (an insert into an empty list needs no link step); a read or delete walks to
// its position, and a delete then unlinks the node and frees its slot.
// The walk from the first node follows one link per cycle through the
// node_next memory port.
// A new request is accepted in the cycle after the response is loaded; the
// engine does not take a request before it is through with the last one.
// If the receiver stalls, the finished response waits in the output register;
// one more request may be accepted and worked, then the engine holds its
// response until the register frees up.
// Reset (synchronous) empties the list and the free stack; the node memories
// need no clearing, an entry is only read after it has been written.
`default_nettype none

module positional_list_engine #(
   parameter int CAPACITY = 1024
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire ple_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output ple_pkg::rsp_type     rsp_data
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LEN_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (LEN_W > ple_pkg::POS_W) ? LEN_W : ple_pkg::POS_W;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_TAKE   = 7'b0000010,
      ST_WALK   = 7'b0000100,
      ST_NODE   = 7'b0001000,
      ST_LINK   = 7'b0010000,
      ST_UNLINK = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {
      MODE_EMPTY,
      MODE_HEAD,
      MODE_TAIL,
      MODE_MID
   } link_mode_type;

   // node store and free stack
   logic signed [ple_pkg::VALUE_W-1:0] node_value [CAPACITY];
   logic [IDX_W-1:0] node_next  [CAPACITY];
   logic [IDX_W-1:0] node_prev  [CAPACITY];
   logic [IDX_W-1:0] free_stack [CAPACITY];

   logic signed [ple_pkg::VALUE_W-1:0] value_rd_ff;
   logic [IDX_W-1:0] next_rd_ff;
   logic [IDX_W-1:0] prev_rd_ff;
   logic [IDX_W-1:0] free_rd_ff;

   state_type state_ff, state_in;
   link_mode_type mode_ff, mode_in;
   logic [ple_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [ple_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [ple_pkg::POS_W-1:0]  rem_ff, rem_in;
   logic signed [ple_pkg::VALUE_W-1:0] val_ff, val_in;
   logic signed [ple_pkg::VALUE_W-1:0] res_value_ff, res_value_in;
   logic [ple_pkg::STATUS_W-1:0] res_status_ff, res_status_in;

   logic [IDX_W-1:0] first_ff, first_in;
   logic [IDX_W-1:0] last_ff, last_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] free_count_ff, free_count_in;
   logic [LEN_W-1:0] fresh_ff, fresh_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [IDX_W-1:0] pred_ff, pred_in;
   logic [IDX_W-1:0] succ_ff, succ_in;
   logic [IDX_W-1:0] slot_ff, slot_in;

   logic rsp_valid_ff, rsp_valid_in;
   ple_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // memory port controls
   logic [IDX_W-1:0] rd_addr;
   logic value_we, next_we, prev_we, free_we;
   logic [IDX_W-1:0] value_wa, next_wa, prev_wa;
   logic [IDX_W-1:0] next_wd, prev_wd;
   logic [IDX_W-1:0] free_wa, free_ra;

   logic accept;
   logic [CMP_W-1:0] req_pos_ext, pos_ext, len_ext;
   logic full;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign req_pos_ext = CMP_W'(req_data.position);
   assign pos_ext     = CMP_W'(pos_ff);
   assign len_ext     = CMP_W'(len_ff);
   assign full        = (len_ff == LEN_W'(CAPACITY));

   assign free_wa = free_count_ff[IDX_W-1:0];
   assign free_ra = IDX_W'(free_count_ff - LEN_W'(1));

   always_ff @(posedge clock) begin
      if (value_we) node_value[value_wa] <= val_ff;
      value_rd_ff <= node_value[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (next_we) node_next[next_wa] <= next_wd;
      next_rd_ff <= node_next[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (prev_we) node_prev[prev_wa] <= prev_wd;
      prev_rd_ff <= node_prev[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (free_we) free_stack[free_wa] <= cur_ff;
      free_rd_ff <= free_stack[free_ra];
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      kind_in       = kind_ff;
      pos_in        = pos_ff;
      rem_in        = rem_ff;
      val_in        = val_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      len_in        = len_ff;
      free_count_in = free_count_ff;
      fresh_in      = fresh_ff;
      cur_in        = cur_ff;
      pred_in       = pred_ff;
      succ_in       = succ_ff;
      slot_in       = slot_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      rd_addr  = cur_ff;
      value_we = 1'b0;
      next_we  = 1'b0;
      prev_we  = 1'b0;
      free_we  = 1'b0;
      value_wa = slot_ff;
      next_wa  = slot_ff;
      prev_wa  = slot_ff;
      next_wd  = '0;
      prev_wd  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in       = req_data.kind;
               pos_in        = req_data.position;
               rem_in        = req_data.position;
               val_in        = req_data.value;
               res_value_in  = '0;
               res_status_in = ple_pkg::STATUS_DONE;
               cur_in        = first_ff;
               rd_addr       = first_ff;
               state_in      = ST_FINISH;
               case (req_data.kind)
                  ple_pkg::KIND_READ: begin
                     if (req_pos_ext < len_ext) begin
                        state_in = ST_WALK;
                     end else begin
                        res_value_in  = ple_pkg::READ_MISS;
                        res_status_in = ple_pkg::STATUS_RANGE;
                     end
                  end
                  ple_pkg::KIND_INS_HEAD, ple_pkg::KIND_INS_TAIL: begin
                     if (full) res_status_in = ple_pkg::STATUS_FULL;
                     else state_in = ST_TAKE;
                  end
                  ple_pkg::KIND_INS_AT: begin
                     if (req_pos_ext > len_ext) res_status_in = ple_pkg::STATUS_RANGE;
                     else if (full) res_status_in = ple_pkg::STATUS_FULL;
                     else state_in = ST_TAKE;
                  end
                  ple_pkg::KIND_DELETE: begin
                     if (req_pos_ext < len_ext) state_in = ST_WALK;
                     else res_status_in = ple_pkg::STATUS_RANGE;
                  end
                  default: begin
                     res_status_in = ple_pkg::STATUS_RANGE;
                  end
               endcase
            end
         end

         ST_TAKE: begin
            // reuse a released slot first, else hand out the next fresh one
            if (free_count_ff != '0) begin
               slot_in       = free_rd_ff;
               free_count_in = free_count_ff - LEN_W'(1);
            end else begin
               slot_in = fresh_ff[IDX_W-1:0];
               if (fresh_ff < LEN_W'(CAPACITY)) fresh_in = fresh_ff + LEN_W'(1);
            end
            if (len_ff == '0) begin
               mode_in = MODE_EMPTY;
            end else if (kind_ff == ple_pkg::KIND_INS_HEAD ||
                         (kind_ff == ple_pkg::KIND_INS_AT && pos_ext == '0)) begin
               mode_in = MODE_HEAD;
            end else if (kind_ff == ple_pkg::KIND_INS_TAIL ||
                         (kind_ff == ple_pkg::KIND_INS_AT && pos_ext == len_ext)) begin
               mode_in = MODE_TAIL;
            end else begin
               mode_in = MODE_MID;
            end
            state_in = (mode_in == MODE_MID) ? ST_WALK : ST_NODE;
         end

         ST_WALK: begin
            // read registers hold the entry at cur_ff
            if (rem_ff != '0) begin
               cur_in  = next_rd_ff;
               rd_addr = next_rd_ff;
               rem_in  = rem_ff - ple_pkg::POS_W'(1);
            end else begin
               pred_in = prev_rd_ff;
               succ_in = next_rd_ff;
               case (kind_ff)
                  ple_pkg::KIND_READ: begin
                     res_value_in = value_rd_ff;
                     state_in     = ST_FINISH;
                  end
                  ple_pkg::KIND_DELETE: state_in = ST_UNLINK;
                  default:              state_in = ST_NODE;
               endcase
            end
         end

         ST_NODE: begin
            value_we = 1'b1;
            next_we  = 1'b1;
            prev_we  = 1'b1;
            case (mode_ff)
               MODE_HEAD: next_wd = first_ff;
               MODE_TAIL: prev_wd = last_ff;
               MODE_MID: begin
                  next_wd = cur_ff;
                  prev_wd = pred_ff;
               end
               default: begin
                  next_wd = '0;
                  prev_wd = '0;
               end
            endcase
            if (mode_ff == MODE_EMPTY) begin
               first_in = slot_ff;
               last_in  = slot_ff;
               len_in   = len_ff + LEN_W'(1);
               state_in = ST_FINISH;
            end else begin
               state_in = ST_LINK;
            end
         end

         ST_LINK: begin
            next_wd = slot_ff;
            prev_wd = slot_ff;
            case (mode_ff)
               MODE_HEAD: begin
                  prev_we  = 1'b1;
                  prev_wa  = first_ff;
                  first_in = slot_ff;
               end
               MODE_TAIL: begin
                  next_we = 1'b1;
                  next_wa = last_ff;
                  last_in = slot_ff;
               end
               default: begin
                  next_we = 1'b1;
                  next_wa = pred_ff;
                  prev_we = 1'b1;
                  prev_wa = cur_ff;
               end
            endcase
            len_in   = len_ff + LEN_W'(1);
            state_in = ST_FINISH;
         end

         ST_UNLINK: begin
            if (len_ff == LEN_W'(1)) begin
               first_in = '0;
               last_in  = '0;
            end else begin
               if (pos_ext == '0) begin
                  first_in = succ_ff;
               end else begin
                  next_we = 1'b1;
                  next_wa = pred_ff;
                  next_wd = succ_ff;
               end
               if (pos_ext == len_ext - CMP_W'(1)) begin
                  last_in = pred_ff;
               end else begin
                  prev_we = 1'b1;
                  prev_wa = succ_ff;
                  prev_wd = pred_ff;
               end
            end
            if (free_count_ff < LEN_W'(CAPACITY)) begin
               free_we       = 1'b1;
               free_count_in = free_count_ff + LEN_W'(1);
            end
            len_in   = len_ff - LEN_W'(1);
            state_in = ST_FINISH;
         end

         ST_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.read_value = res_value_ff;
               rsp_data_in.status     = res_status_ff;
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         first_ff      <= '0;
         last_ff       <= '0;
         len_ff        <= '0;
         free_count_ff <= '0;
         fresh_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_ff      <= first_in;
         last_ff       <= last_in;
         len_ff        <= len_in;
         free_count_ff <= free_count_in;
         fresh_ff      <= fresh_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      kind_ff       <= kind_in;
      pos_ff        <= pos_in;
      rem_ff        <= rem_in;
      val_ff        <= val_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      cur_ff        <= cur_in;
      pred_ff       <= pred_in;
      succ_ff       <= succ_in;
      slot_ff       <= slot_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

`default_nettype wire
